// ===== src/cahm_pkg.sv =====
// ----------------------------------------------------------------------------
// cahm_pkg
// Field widths, command and status codes, and the transfer types of the
// code address hash map.
// ----------------------------------------------------------------------------
package cahm_pkg;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] payload;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] found_handle;
    } rsp_t;

endpackage

// ===== src/code_address_hash_map.sv =====
// ----------------------------------------------------------------------------
// code_address_hash_map
// Map from code start address to method handle, held in bucket rows of a
// single synchronous memory.
// ----------------------------------------------------------------------------
// One request gives one response. Sustained rate is one request per cycle
// while rsp_stall is low: each bucket is one memory row holding its fill and
// all ways, read into the row stage and written back from it, with the row
// just written forwarded to a following request for the same bucket. A
// request passes the index stage (hash and a reciprocal multiply for the
// mod), the row stage (bucket index and row read) and the output register
// (compare and response). After reset the block clears the fill of every
// bucket, one row per cycle, and holds req_stall high until the last row is
// cleared. Keys are cut to KEY_BITS bits (at most the 32-bit field) before
// hashing and compare; the bucket is ((key >> 2) ^ (key >> 9)) mod BUCKETS.
module code_address_hash_map #(
    parameter int BUCKETS  = 128,
    parameter int WAYS     = 4,
    parameter int KEY_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cahm_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output cahm_pkg::rsp_t  rsp
);

    localparam int HND_W = cahm_pkg::HANDLE_W;
    localparam int KW    = (KEY_BITS < cahm_pkg::KEY_W) ? KEY_BITS : cahm_pkg::KEY_W;
    localparam int HW    = KW - 2;
    localparam int BW    = $clog2(BUCKETS);
    localparam int FW    = $clog2(WAYS + 1);
    localparam int ROW_W = FW + WAYS * KW + WAYS * HND_W;
    localparam int SH    = HW + BW;
    localparam int MW    = HW + 2;
    localparam int PW    = HW + MW;
    localparam int QW    = PW - SH;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SH) + longint'(BUCKETS) - 64'd1) / longint'(BUCKETS);
    localparam logic [MW-1:0] RECIP     = MW'(RECIP_FULL);
    localparam logic [BW:0]   BUCKETS_W = (BW + 1)'(BUCKETS);
    localparam logic [BW-1:0] LAST_ROW  = BW'(BUCKETS - 1);

    // clearing pass
    logic          clr_active_reg, clr_active_next;
    logic [BW-1:0] clr_addr_reg, clr_addr_next;

    // index stage
    logic                 a_valid_reg, a_valid_next;
    cahm_pkg::req_t       a_req_reg;
    logic [HW-1:0]        a_hash_reg;
    logic [QW-1:0]        a_quot_reg;

    // row stage
    logic                 b_valid_reg, b_valid_next;
    cahm_pkg::req_t       b_req_reg;
    logic [BW-1:0]        b_bucket_reg;
    logic [ROW_W-1:0]     row_rd_reg;
    logic                 fwd_reg, fwd_next;
    logic [ROW_W-1:0]     fwd_row_reg;

    // output register
    logic                 rsp_valid_reg, rsp_valid_next;
    cahm_pkg::rsp_t       rsp_reg;

    logic [ROW_W-1:0]     mem [BUCKETS];

    logic [KW-1:0]        key_in;
    logic [HW-1:0]        hash_in;
    logic [PW-1:0]        prod_in;
    logic [HW-1:0]        qb;
    logic [HW-1:0]        rem_full;
    logic [BW:0]          rem_low;
    logic [BW-1:0]        bucket_a;

    logic                 req_take;
    logic                 a_go;
    logic                 b_go;

    logic [ROW_W-1:0]               row_cur;
    logic [FW-1:0]                  cur_fill;
    logic [WAYS-1:0][KW-1:0]        cur_keys;
    logic [WAYS-1:0][HND_W-1:0]     cur_handles;
    logic [FW-1:0]                  new_fill;
    logic [WAYS-1:0][KW-1:0]        new_keys;
    logic [WAYS-1:0][HND_W-1:0]     new_handles;
    logic [ROW_W-1:0]               new_row;
    logic                           row_write;
    cahm_pkg::rsp_t                 row_rsp;

    logic                 mem_we;
    logic [BW-1:0]        mem_waddr;
    logic [ROW_W-1:0]     mem_wdata;

    // handshake
    assign b_go      = b_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign a_go      = a_valid_reg && (!b_valid_reg || b_go);
    assign req_stall = clr_active_reg || (a_valid_reg && !a_go);
    assign req_take  = req_valid && !req_stall;

    // hash and quotient estimate straight from the request
    assign key_in  = req.key[KW-1:0];
    assign hash_in = key_in[KW-1:2] ^ HW'(key_in >> 9);
    assign prod_in = PW'(hash_in) * PW'(RECIP);

    // remainder with one correction step
    assign qb       = HW'(a_quot_reg) * HW'(BUCKETS);
    assign rem_full = a_hash_reg - qb;
    assign rem_low  = rem_full[BW:0];
    assign bucket_a = (rem_low >= BUCKETS_W) ? BW'(rem_low - BUCKETS_W) : rem_low[BW-1:0];

    // row just written takes the place of the stale read
    assign row_cur     = fwd_reg ? fwd_row_reg : row_rd_reg;
    assign cur_fill    = row_cur[ROW_W-1 -: FW];
    assign cur_keys    = row_cur[WAYS*(KW+HND_W)-1 -: WAYS*KW];
    assign cur_handles = row_cur[WAYS*HND_W-1:0];
    assign new_row     = {new_fill, new_keys, new_handles};

    cahm_row_op #(
        .WAYS (WAYS),
        .KW   (KW),
        .FW   (FW)
    ) u_row_op (
        .req          (b_req_reg),
        .fill         (cur_fill),
        .keys         (cur_keys),
        .handles      (cur_handles),
        .fill_next    (new_fill),
        .keys_next    (new_keys),
        .handles_next (new_handles),
        .row_write    (row_write),
        .rsp          (row_rsp)
    );

    assign mem_we    = clr_active_reg || (b_go && row_write);
    assign mem_waddr = clr_active_reg ? clr_addr_reg : b_bucket_reg;
    assign mem_wdata = clr_active_reg ? '0 : new_row;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + BW'(1);
            if (clr_addr_reg == LAST_ROW)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (req_take)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_go)
        begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (a_go)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_go)
        begin
            b_valid_next = 1'b0;
        end

        fwd_next = fwd_reg;
        if (a_go)
        begin
            fwd_next = b_go && row_write && (b_bucket_reg == bucket_a);
        end

        rsp_valid_next = rsp_valid_reg;
        if (b_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            fwd_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            fwd_reg        <= fwd_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            a_req_reg  <= req;
            a_hash_reg <= hash_in;
            a_quot_reg <= prod_in[PW-1:SH];
        end
        if (a_go)
        begin
            b_req_reg    <= a_req_reg;
            b_bucket_reg <= bucket_a;
            fwd_row_reg  <= new_row;
        end
        if (b_go)
        begin
            rsp_reg <= row_rsp;
        end
    end

    // bucket row memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (a_go)
        begin
            row_rd_reg <= mem[bucket_a];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/cahm_row_op.sv =====
// ----------------------------------------------------------------------------
// cahm_row_op
// Applies one command to a bucket row: compares all ways at once, finds the
// newest match, and builds the row to write back and the response.
// ----------------------------------------------------------------------------
module cahm_row_op #(
    parameter int WAYS = 4,
    parameter int KW   = 32,
    parameter int FW   = 3
) (
    input  cahm_pkg::req_t                               req,
    input  logic [FW-1:0]                                fill,
    input  logic [WAYS-1:0][KW-1:0]                      keys,
    input  logic [WAYS-1:0][cahm_pkg::HANDLE_W-1:0]      handles,
    output logic [FW-1:0]                                fill_next,
    output logic [WAYS-1:0][KW-1:0]                      keys_next,
    output logic [WAYS-1:0][cahm_pkg::HANDLE_W-1:0]      handles_next,
    output logic                                         row_write,
    output cahm_pkg::rsp_t                               rsp
);

    localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [KW-1:0]  key_cut;
    logic           hit;
    logic [WIW-1:0] hit_way;

    assign key_cut = req.key[KW-1:0];

    // later ways are newer, so the last hit wins
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (FW'(w) < fill && keys[w] == key_cut)
            begin
                hit     = 1'b1;
                hit_way = WIW'(w);
            end
        end
    end

    always_comb
    begin
        fill_next        = fill;
        keys_next        = keys;
        handles_next     = handles;
        row_write        = 1'b0;
        rsp.status       = cahm_pkg::STATUS_MISS;
        rsp.found_handle = '0;
        case (req.command)
            cahm_pkg::CMD_LOOKUP:
            begin
                if (hit)
                begin
                    rsp.status       = cahm_pkg::STATUS_OK;
                    rsp.found_handle = handles[hit_way];
                end
            end
            cahm_pkg::CMD_INSERT:
            begin
                if (fill >= FW'(WAYS))
                begin
                    rsp.status = cahm_pkg::STATUS_FULL;
                end
                else
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (FW'(w) == fill)
                        begin
                            keys_next[w]    = key_cut;
                            handles_next[w] = req.payload;
                        end
                    end
                    fill_next  = fill + FW'(1);
                    row_write  = 1'b1;
                    rsp.status = cahm_pkg::STATUS_OK;
                end
            end
            cahm_pkg::CMD_REMOVE:
            begin
                if (hit)
                begin
                    // newer entries move down one way
                    for (int w = 0; w < WAYS - 1; w++)
                    begin
                        if (WIW'(w) >= hit_way)
                        begin
                            keys_next[w]    = keys[w+1];
                            handles_next[w] = handles[w+1];
                        end
                    end
                    fill_next  = fill - FW'(1);
                    row_write  = 1'b1;
                    rsp.status = cahm_pkg::STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sim/tb_code_address_hash_map.sv =====
// ----------------------------------------------------------------------------
// tb_code_address_hash_map
// Self-checking bench for the code address hash map. A directed table covers
// empty-map misses, extreme keys and handles, duplicates, a full bucket,
// removal with compaction and the unused command. Random traffic follows,
// mostly on a few crowded buckets so that hits, full buckets and removals
// stay frequent. A shadow copy of the buckets predicts each answer that the
// table does not give, and both sides of the block idle at random.
// ----------------------------------------------------------------------------
module tb_code_address_hash_map;

    localparam int BUCKETS        = 128;
    localparam int WAYS           = 4;
    localparam int RANDOM_ITEMS   = 1280;
    localparam int POOL_SIZE      = 16;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [cahm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        cahm_pkg::req_t item;
        bit             typed;
        cahm_pkg::rsp_t want;
    } row_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    cahm_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    cahm_pkg::rsp_t rsp;

    // shadow of the bucket store
    logic [2:0]                    shadow_fill    [BUCKETS];
    logic [cahm_pkg::KEY_W-1:0]    shadow_keys    [BUCKETS][WAYS];
    logic [cahm_pkg::HANDLE_W-1:0] shadow_handles [BUCKETS][WAYS];

    cahm_pkg::rsp_t             answers_due [$];
    logic [cahm_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    row_t                       directed_rows [20];

    int  mismatches   = 0;
    int  quiet_cycles = 0;
    bit  calm;

    code_address_hash_map uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic row_t vec(logic [cahm_pkg::CMD_W-1:0] cmd,
                                 logic [cahm_pkg::KEY_W-1:0] key,
                                 logic [cahm_pkg::HANDLE_W-1:0] handle, bit typed,
                                 logic [cahm_pkg::STATUS_W-1:0] status,
                                 logic [cahm_pkg::HANDLE_W-1:0] found);
        row_t r;
        r.item.command      = cmd;
        r.item.key          = key;
        r.item.payload      = handle;
        r.typed             = typed;
        r.want.status       = status;
        r.want.found_handle = found;
        return r;
    endfunction

    function automatic logic [6:0] bucket_of_key(logic [cahm_pkg::KEY_W-1:0] key);
        logic [cahm_pkg::KEY_W-1:0] mixed;
        mixed = (key >> 2) ^ (key >> 9);
        return mixed[6:0];
    endfunction

    // applies one command to the shadow map and returns its answer
    function automatic cahm_pkg::rsp_t map_apply(cahm_pkg::req_t r);
        cahm_pkg::rsp_t a;
        logic [6:0]     b;
        int             fill;
        int             hit_way;
        b       = bucket_of_key(r.key);
        fill    = int'(shadow_fill[b]);
        hit_way = -1;
        a.status       = cahm_pkg::STATUS_MISS;
        a.found_handle = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (w < fill && shadow_keys[b][w] == r.key)
                hit_way = w;
        end
        case (r.command)
            cahm_pkg::CMD_LOOKUP:
            begin
                if (hit_way >= 0)
                begin
                    a.status       = cahm_pkg::STATUS_OK;
                    a.found_handle = shadow_handles[b][hit_way];
                end
            end
            cahm_pkg::CMD_INSERT:
            begin
                if (fill >= WAYS)
                    a.status = cahm_pkg::STATUS_FULL;
                else
                begin
                    shadow_keys[b][fill]    = r.key;
                    shadow_handles[b][fill] = r.payload;
                    shadow_fill[b]          = 3'(fill + 1);
                    a.status                = cahm_pkg::STATUS_OK;
                end
            end
            cahm_pkg::CMD_REMOVE:
            begin
                if (hit_way >= 0)
                begin
                    for (int j = hit_way; j + 1 < fill; j++)
                    begin
                        shadow_keys[b][j]    = shadow_keys[b][j+1];
                        shadow_handles[b][j] = shadow_handles[b][j+1];
                    end
                    shadow_fill[b] = 3'(fill - 1);
                    a.status       = cahm_pkg::STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    // keys crowded into three buckets, upper bits random
    function automatic void refill_key_pool();
        logic [6:0]                 crowded [3];
        logic [cahm_pkg::KEY_W-1:0] k;
        for (int i = 0; i < 3; i++)
            crowded[i] = 7'($urandom_range(BUCKETS - 1));
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            k       = $urandom;
            k[8:2]  = crowded[$urandom_range(2)] ^ k[15:9];
            key_pool[i] = k;
        end
    endfunction

    task automatic send(row_t r);
        cahm_pkg::rsp_t predicted;
        while (!calm && $urandom_range(99) < 33)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r.item;
        do
            @(posedge clk);
        while (req_stall);
        // transfer taken at this edge
        predicted = map_apply(r.item);
        answers_due.push_back(r.typed ? r.want : predicted);
    endtask

    always @(posedge clk)
    begin
        if (calm)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < 33);
    end

    always @(posedge clk)
    begin
        cahm_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("response with no request outstanding: status %0d handle %h",
                       rsp.status, rsp.found_handle);
                mismatches++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatches++;
                end
                if (rsp.found_handle !== want.found_handle)
                begin
                    $error("found_handle: expected %h, got %h",
                           want.found_handle, rsp.found_handle);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("code_address_hash_map verification failed");
            $finish;
        end
    end

    initial
    begin
        row_t r;
        int   sel;
        int   pick;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        calm         = 1'b0;
        for (int b = 0; b < BUCKETS; b++)
            shadow_fill[b] = '0;

        // both extreme keys land in bucket zero, as do 0x204 and 0x80000001
        directed_rows = '{
            vec(cahm_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0,
                1'b1, cahm_pkg::STATUS_MISS, 32'h0),
            vec(cahm_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0,
                1'b1, cahm_pkg::STATUS_MISS, 32'h0),
            vec(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                1'b1, cahm_pkg::STATUS_MISS, 32'h0),
            vec(cahm_pkg::CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF,
                1'b1, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000,
                1'b1, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0,
                1'b1, cahm_pkg::STATUS_OK, 32'hFFFF_FFFF),
            vec(cahm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h1,
                1'b1, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_1234,
                1'b1, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0,
                1'b0, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_INSERT, 32'h0000_0204, 32'h5A5A_A5A5,
                1'b1, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_INSERT, 32'h8000_0001, 32'h0BAD_F00D,
                1'b1, cahm_pkg::STATUS_FULL, 32'h0),
            vec(cahm_pkg::CMD_LOOKUP, 32'h8000_0001, 32'h0,
                1'b1, cahm_pkg::STATUS_MISS, 32'h0),
            vec(cahm_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0,
                1'b1, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0,
                1'b0, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_LOOKUP, 32'h0000_0204, 32'h0,
                1'b0, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0,
                1'b1, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0,
                1'b1, cahm_pkg::STATUS_MISS, 32'h0),
            vec(cahm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0,
                1'b0, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_INSERT, 32'h8000_0001, 32'h0BAD_F00D,
                1'b1, cahm_pkg::STATUS_OK, 32'h0),
            vec(cahm_pkg::CMD_LOOKUP, 32'hAAAA_5555, 32'h0,
                1'b0, cahm_pkg::STATUS_OK, 32'h0)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send(directed_rows[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 250 == 0)
                refill_key_pool();
            calm = (n >= 500 && n < 700);
            sel  = $urandom_range(99);
            r    = '0;
            if (sel < 85)
            begin
                pick         = $urandom_range(99);
                r.item.key   = key_pool[$urandom_range(POOL_SIZE - 1)];
                r.item.command = (pick < 40) ? cahm_pkg::CMD_INSERT :
                                 (pick < 75) ? cahm_pkg::CMD_LOOKUP : cahm_pkg::CMD_REMOVE;
                r.item.payload = ($urandom_range(9) == 0) ? '0 :
                                 cahm_pkg::HANDLE_W'($urandom);
            end
            else
            begin
                r.item.command = cahm_pkg::CMD_W'($urandom_range(3));
                r.item.key     = $urandom;
                r.item.payload = $urandom;
            end
            send(r);
        end
        req_valid <= 1'b0;
        calm = 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("code_address_hash_map verification clean");
        else
            $display("code_address_hash_map verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/cahm_pkg.sv
src/cahm_row_op.sv
src/code_address_hash_map.sv
sim/tb_code_address_hash_map.sv
